// File: rtl/plist_pkg.sv
// Shared constants, codes and types for the positional list engine.
package plist_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;
   localparam int KIND_W   = 3;
   localparam int POS_W    = 7;
   localparam int STAT_W   = 2;

   localparam logic [KIND_W-1:0] REQ_APPEND   = 3'd0;
   localparam logic [KIND_W-1:0] REQ_INSERT   = 3'd1;
   localparam logic [KIND_W-1:0] REQ_DEL_LAST = 3'd2;
   localparam logic [KIND_W-1:0] REQ_DEL_AT   = 3'd3;
   localparam logic [KIND_W-1:0] REQ_READ     = 3'd4;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic                     valid;
      status_type               status;
      logic [CNT_W-1:0]         count;
      logic signed [WORD_W-1:0] value;
   } result_type;

endpackage

// File: rtl/plist_ram.sv
// Generic single write port, single read port RAM with registered read data.
module plist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/plist_ctrl.sv
// Request sequencer: decodes a request and moves list cells one at a time.
module plist_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [plist_pkg::KIND_W-1:0]          req_kind,
   input  logic [plist_pkg::POS_W-1:0]           req_pos,
   input  logic signed [plist_pkg::WORD_W-1:0]   req_word,
   output logic                                  ready,
   input  logic                                  take,
   output plist_pkg::result_type                 result,
   output logic                                  ram_we,
   output logic [plist_pkg::ADDR_W-1:0]          ram_wr_addr,
   output logic [plist_pkg::WORD_W-1:0]          ram_wr_data,
   output logic [plist_pkg::ADDR_W-1:0]          ram_rd_addr,
   input  logic [plist_pkg::WORD_W-1:0]          ram_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_RD_ISSUE,
      S_RD_WAIT,
      S_FINISH
   } state_type;

   state_type                            state_ff, state_in;
   logic [plist_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [plist_pkg::ADDR_W-1:0]         idx_ff, idx_in;
   logic [plist_pkg::ADDR_W-1:0]         at_ff, at_in;
   logic [plist_pkg::ADDR_W-1:0]         lim_ff, lim_in;
   logic                                 up_ff, up_in;
   logic signed [plist_pkg::WORD_W-1:0]  word_ff, word_in;
   plist_pkg::status_type                status_ff, status_in;
   logic signed [plist_pkg::WORD_W-1:0]  rdval_ff, rdval_in;

   logic [plist_pkg::ADDR_W-1:0]         src;
   logic [plist_pkg::ADDR_W-1:0]         at_req;
   logic [plist_pkg::ADDR_W-1:0]         last_idx;
   logic                                 pos_ok;
   logic                                 full;

   // shared index unit: step toward the source cell and compare with the bound
   assign src      = up_ff ? idx_ff + 1'b1 : idx_ff - 1'b1;
   assign at_req   = plist_pkg::ADDR_W'(req_pos - 1'b1);
   assign last_idx = plist_pkg::ADDR_W'(count_ff - 1'b1);
   assign pos_ok   = (req_pos != '0) && (req_pos <= plist_pkg::POS_W'(count_ff));
   assign full     = (count_ff == plist_pkg::CNT_W'(plist_pkg::CAPACITY));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      at_in       = at_ff;
      lim_in      = lim_ff;
      up_in       = up_ff;
      word_in     = word_ff;
      status_in   = status_ff;
      rdval_in    = rdval_ff;
      ram_we      = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = src;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = plist_pkg::ST_OK;
               rdval_in  = '0;
               word_in   = req_word;
               at_in     = at_req;
               state_in  = S_FINISH;
               unique case (req_kind)
                  plist_pkg::REQ_APPEND: begin
                     if (full) begin
                        status_in = plist_pkg::ST_FULL;
                     end else begin
                        ram_we      = 1'b1;
                        ram_wr_addr = plist_pkg::ADDR_W'(count_ff);
                        ram_wr_data = req_word;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  plist_pkg::REQ_INSERT: begin
                     if (!pos_ok) begin
                        status_in = plist_pkg::ST_INVALID;
                     end else if (full) begin
                        status_in = plist_pkg::ST_FULL;
                     end else begin
                        idx_in   = plist_pkg::ADDR_W'(count_ff);
                        lim_in   = at_req;
                        up_in    = 1'b0;
                        state_in = S_SHIFT_RD;
                     end
                  end
                  plist_pkg::REQ_DEL_LAST: begin
                     if (count_ff == '0) begin
                        status_in = plist_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  plist_pkg::REQ_DEL_AT: begin
                     if (!pos_ok) begin
                        status_in = plist_pkg::ST_INVALID;
                     end else begin
                        idx_in = at_req;
                        lim_in = last_idx;
                        up_in  = 1'b1;
                        if (at_req == last_idx) begin
                           count_in = count_ff - 1'b1;
                        end else begin
                           state_in = S_SHIFT_RD;
                        end
                     end
                  end
                  plist_pkg::REQ_READ: begin
                     if (!pos_ok) begin
                        status_in = plist_pkg::ST_INVALID;
                     end else begin
                        state_in = S_RD_ISSUE;
                     end
                  end
                  default: begin
                     status_in = plist_pkg::ST_INVALID;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            ram_rd_addr = src;
            state_in    = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            ram_we      = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data;
            idx_in      = src;
            if (src == lim_ff) begin
               if (up_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_PLACE: begin
            ram_we      = 1'b1;
            ram_wr_addr = at_ff;
            ram_wr_data = word_ff;
            count_in    = count_ff + 1'b1;
            state_in    = S_FINISH;
         end
         S_RD_ISSUE: begin
            ram_rd_addr = at_ff;
            state_in    = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            rdval_in = ram_rd_data;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      at_ff     <= at_in;
      lim_ff    <= lim_in;
      up_ff     <= up_in;
      word_ff   <= word_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   assign ready         = (state_ff == S_IDLE);
   assign result.valid  = (state_ff == S_FINISH);
   assign result.status = status_ff;
   assign result.count  = count_ff;
   assign result.value  = rdval_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= plist_pkg::CNT_W'(plist_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && ready |=> !ready)
      else $error("sequencer idle right after taking a request");

   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT_WR |-> $past(state_ff) == S_SHIFT_RD)
      else $error("shift write without a preceding read");

   a_place_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PLACE |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the list");
`endif

endmodule

// File: rtl/positional_list_engine_core.sv
// Top level of the positional list engine: sequencer, cell RAM, result register.
// Append, delete-last and rejected requests go straight to S_FINISH; a read passes
// S_RD_ISSUE and S_RD_WAIT; insert moves k cells and then writes the new word in S_PLACE;
// delete-at moves k cells (k = cells moved; each move is a read state and then a write state
// on the one-read, one-write cell RAM). One request at a time: req_ready returns on the edge
// that loads rsp_valid; a low rsp_ready holds it longer. Sync reset empties the list at once.
module positional_list_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [plist_pkg::KIND_W-1:0]        req_type,
   input  logic [plist_pkg::POS_W-1:0]         req_position,
   input  logic signed [plist_pkg::WORD_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [plist_pkg::STAT_W-1:0]        rsp_status,
   output logic [plist_pkg::POS_W-1:0]         rsp_entry_count,
   output logic signed [plist_pkg::WORD_W-1:0] rsp_read_value
);

   plist_pkg::result_type              result;
   logic                               seq_ready;
   logic                               out_free;
   logic                               ram_we;
   logic [plist_pkg::ADDR_W-1:0]       ram_wr_addr;
   logic [plist_pkg::WORD_W-1:0]       ram_wr_data;
   logic [plist_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [plist_pkg::WORD_W-1:0]       ram_rd_data;

   // output register: a finished word may wait here while the next one runs
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [plist_pkg::STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [plist_pkg::POS_W-1:0]         rsp_count_ff, rsp_count_in;
   logic signed [plist_pkg::WORD_W-1:0] rsp_value_ff, rsp_value_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = seq_ready;

   plist_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (req_valid),
      .req_kind    (req_type),
      .req_pos     (req_position),
      .req_word    (req_value),
      .ready       (seq_ready),
      .take        (out_free),
      .result      (result),
      .ram_we      (ram_we),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // list cells, position 1 in cell 0
   plist_ram #(
      .WIDTH (plist_pkg::WORD_W),
      .DEPTH (plist_pkg::CAPACITY)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // load a new word when the slot is empty or being drained this cycle
      if (result.valid && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_count_in  = plist_pkg::POS_W'(result.count);
         rsp_value_in  = result.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_read_value  = rsp_value_ff;

endmodule
